[rtl/dlrs_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dlrs_pkg
// Shared opcodes, controller states and command/status bundles of the dense
// layer.
// ----------------------------------------------------------------------------
package dlrs_pkg;

  localparam int DATA_W   = 16;
  localparam int CNT_W    = 5;
  localparam int NIDX_W   = 4;
  localparam int ACT_W    = 15;
  localparam int CFG_IW   = 2;
  localparam int LR_W     = 16;
  localparam int COUNT_MAX = 31;
  localparam int ACT_MAX  = 32767;

  typedef enum logic [2:0] {
    OP_LOAD_W  = 3'd0,
    OP_LOAD_B  = 3'd1,
    OP_LOAD_WG = 3'd2,
    OP_LOAD_BG = 3'd3,
    OP_INPUT   = 3'd4,
    OP_APPLY   = 3'd5,
    OP_RSVD6   = 3'd6,
    OP_RSVD7   = 3'd7
  } opcode_t;

  typedef enum logic [1:0] {
    CFG_INPUTS  = 2'd0,
    CFG_OUTPUTS = 2'd1,
    CFG_LRATE   = 2'd2,
    CFG_NONE    = 2'd3
  } cfg_idx_t;

  localparam logic STATUS_OK  = 1'b0;
  localparam logic STATUS_ERR = 1'b1;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_ERR,
    ST_N_INIT,
    ST_N_LOAD,
    ST_MAC,
    ST_DRAIN,
    ST_FINISH,
    ST_A_RD,
    ST_A_MUL,
    ST_A_WR
  } state_t;

  typedef struct packed {
    logic wr_w;
    logic wr_wg;
    logic wr_b;
    logic wr_bg;
    logic push_x;
    logic end_vec;
    logic mac_vld;
    logic acc_load;
    logic sel_bias;
    logic apply_mul;
    logic apply_wr;
    logic out_load_act;
    logic out_load_err;
    logic out_last;
  } cmd_t;

  typedef struct packed {
    logic             out_free;
    logic [CNT_W-1:0] count;
  } sts_t;

endpackage

[rtl/dlrs_ctrl.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dlrs_ctrl
// Sequencer of the dense layer: takes items, holds the configuration and
// steps the datapath through loads, neuron sums and the weight update.
// ----------------------------------------------------------------------------
module dlrs_ctrl
  import dlrs_pkg::*;
#(
  parameter int MAX_INPUTS  = 16,
  parameter int MAX_OUTPUTS = 16,
  parameter int RowW        = 4,
  parameter int ColW        = 4
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [2:0]        in_opcode,
  input  logic [3:0]        in_row_index,
  input  logic [3:0]        in_col_index,
  input  logic              in_vector_end,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [CFG_IW-1:0] cfg_index,
  input  logic [LR_W-1:0]   cfg_data,
  output logic [LR_W-1:0]   learn_rate,
  output logic [RowW-1:0]   row,
  output logic [ColW-1:0]   col,
  output logic [NIDX_W-1:0] nidx,
  output cmd_t              cmd,
  input  sts_t              sts
);

  localparam int OutCap = (MAX_OUTPUTS < 16) ? MAX_OUTPUTS : 16;

  state_t           state_r, state_nxt;
  logic [CNT_W-1:0] iiu_r, iiu_nxt;
  logic [CNT_W-1:0] oiu_r, oiu_nxt;
  logic [LR_W-1:0]  lr_r, lr_nxt;
  logic [CNT_W-1:0] i_r, i_nxt;
  logic [CNT_W-1:0] z_r, z_nxt;
  logic             dr_r, dr_nxt;
  logic             bph_r, bph_nxt;

  logic             accept;
  opcode_t          op;
  logic             rc_ok;
  logic             c_ok;
  logic [CNT_W-1:0] cnt_inc;
  logic             match;
  logic [CNT_W-1:0] eff_out;
  logic [CNT_W-1:0] n_in;
  logic             last_z;
  logic             last_i;

  assign in_stall   = (state_r != ST_IDLE);
  assign accept     = in_valid && !in_stall;
  assign op         = opcode_t'(in_opcode);
  assign cfg_ready  = 1'b1;
  assign learn_rate = lr_r;

  assign c_ok    = (32'(in_col_index) < MAX_OUTPUTS);
  assign rc_ok   = (32'(in_row_index) < MAX_INPUTS) && c_ok;
  assign cnt_inc = (32'(sts.count) == COUNT_MAX) ? sts.count : sts.count + 1'b1;
  assign match   = (cnt_inc == iiu_r) && (iiu_r != '0) && (32'(iiu_r) <= MAX_INPUTS);
  assign eff_out = (oiu_r == '0) ? CNT_W'(1) :
                   ((32'(oiu_r) > OutCap) ? CNT_W'(OutCap) : oiu_r);
  assign n_in    = (32'(iiu_r) > MAX_INPUTS) ? CNT_W'(MAX_INPUTS) : iiu_r;
  assign last_i  = ((i_r + 1'b1) == eff_out);
  assign last_z  = bph_r ? 1'b1 : ((z_r + 1'b1) >= n_in);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      iiu_r   <= CNT_W'(16);
      oiu_r   <= CNT_W'(16);
      lr_r    <= '0;
      i_r     <= '0;
      z_r     <= '0;
      dr_r    <= 1'b0;
      bph_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      iiu_r   <= iiu_nxt;
      oiu_r   <= oiu_nxt;
      lr_r    <= lr_nxt;
      i_r     <= i_nxt;
      z_r     <= z_nxt;
      dr_r    <= dr_nxt;
      bph_r   <= bph_nxt;
    end
  end

  always_comb begin
    iiu_nxt = iiu_r;
    oiu_nxt = oiu_r;
    lr_nxt  = lr_r;
    if (cfg_valid && cfg_ready) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_INPUTS:  iiu_nxt = cfg_data[CNT_W-1:0];
        CFG_OUTPUTS: oiu_nxt = cfg_data[CNT_W-1:0];
        CFG_LRATE:   lr_nxt  = cfg_data;
        default:     ;
      endcase
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (accept && op == OP_INPUT && in_vector_end) begin
          state_nxt = match ? ST_N_INIT : ST_ERR;
        end else if (accept && op == OP_APPLY) begin
          state_nxt = ST_A_RD;
        end
      end
      ST_ERR:    if (sts.out_free) state_nxt = ST_IDLE;
      ST_N_INIT: state_nxt = ST_N_LOAD;
      ST_N_LOAD: state_nxt = ST_MAC;
      ST_MAC:    if ((z_r + 1'b1) == iiu_r) state_nxt = ST_DRAIN;
      ST_DRAIN:  if (dr_r) state_nxt = ST_FINISH;
      ST_FINISH: begin
        if (sts.out_free) state_nxt = last_i ? ST_IDLE : ST_N_INIT;
      end
      ST_A_RD:   state_nxt = ST_A_MUL;
      ST_A_MUL:  state_nxt = ST_A_WR;
      ST_A_WR: begin
        if (bph_r && last_i) state_nxt = ST_IDLE;
        else                 state_nxt = ST_A_RD;
      end
      default:   state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd     = '0;
    i_nxt   = i_r;
    z_nxt   = z_r;
    dr_nxt  = dr_r;
    bph_nxt = bph_r;
    row     = RowW'(z_r);
    col     = ColW'(i_r);
    nidx    = NIDX_W'(i_r);
    unique case (state_r)
      ST_IDLE: begin
        row   = RowW'(in_row_index);
        col   = ColW'(in_col_index);
        i_nxt = '0;
        z_nxt = '0;
        if (accept) begin
          unique case (op)
            OP_LOAD_W:  cmd.wr_w  = rc_ok;
            OP_LOAD_WG: cmd.wr_wg = rc_ok;
            OP_LOAD_B:  cmd.wr_b  = c_ok;
            OP_LOAD_BG: cmd.wr_bg = c_ok;
            OP_INPUT: begin
              cmd.push_x  = 1'b1;
              cmd.end_vec = in_vector_end;
            end
            OP_APPLY:   bph_nxt = (n_in == '0);
            default:    ;
          endcase
        end
      end
      ST_ERR: cmd.out_load_err = sts.out_free;
      ST_N_INIT: z_nxt = '0;
      ST_N_LOAD: cmd.acc_load = 1'b1;
      ST_MAC: begin
        cmd.mac_vld = 1'b1;
        z_nxt       = z_r + 1'b1;
        dr_nxt      = 1'b0;
      end
      ST_DRAIN: dr_nxt = !dr_r;
      ST_FINISH: begin
        if (sts.out_free) begin
          cmd.out_load_act = 1'b1;
          cmd.out_last     = last_i;
          i_nxt            = i_r + 1'b1;
        end
      end
      ST_A_RD:  cmd.sel_bias = bph_r;
      ST_A_MUL: begin
        cmd.sel_bias  = bph_r;
        cmd.apply_mul = 1'b1;
      end
      ST_A_WR: begin
        cmd.sel_bias = bph_r;
        cmd.apply_wr = 1'b1;
        cmd.wr_w     = !bph_r;
        cmd.wr_b     = bph_r;
        if (bph_r) begin
          z_nxt   = '0;
          i_nxt   = i_r + 1'b1;
          bph_nxt = (n_in == '0);
        end else if (last_z) begin
          bph_nxt = 1'b1;
        end else begin
          z_nxt = z_r + 1'b1;
        end
      end
      default: ;
    endcase
  end

endmodule

[rtl/dlrs_dp.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dlrs_dp
// Datapath of the dense layer: weight, gradient, bias and input memories,
// multiply-accumulate pipe, update arithmetic and result register.
// ----------------------------------------------------------------------------
module dlrs_dp
  import dlrs_pkg::*;
#(
  parameter int MAX_INPUTS  = 16,
  parameter int MAX_OUTPUTS = 16,
  parameter int RowW        = 4,
  parameter int ColW        = 4
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic signed [DATA_W-1:0] in_data_value,
  input  logic [LR_W-1:0]          learn_rate,
  input  logic [RowW-1:0]          row,
  input  logic [ColW-1:0]          col,
  input  logic [NIDX_W-1:0]        nidx,
  input  cmd_t                     cmd,
  output sts_t                     sts,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic                     out_status,
  output logic [NIDX_W-1:0]        out_neuron_index,
  output logic [ACT_W-1:0]         out_activation,
  output logic                     out_run_end
);

  localparam int Depth = MAX_INPUTS * MAX_OUTPUTS;
  localparam int AddrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int AccW  = 2 * DATA_W + $clog2(MAX_INPUTS + 1) + 1;

  logic signed [DATA_W-1:0] wmem  [Depth];
  logic signed [DATA_W-1:0] gmem  [Depth];
  logic signed [DATA_W-1:0] bmem  [MAX_OUTPUTS];
  logic signed [DATA_W-1:0] bgmem [MAX_OUTPUTS];
  logic signed [DATA_W-1:0] xmem  [MAX_INPUTS];
  logic [MAX_OUTPUTS-1:0]   bv_r;

  logic [AddrW-1:0]           addr;
  logic signed [DATA_W-1:0]   w_rd_r, g_rd_r, b_rd_r, bg_rd_r, x_rd_r;
  logic                       bv_rd_r;
  logic signed [DATA_W-1:0]   bias_val;
  logic                       v1_r, v2_r;
  logic signed [2*DATA_W-1:0] prod_r;
  logic signed [AccW-1:0]     acc_r;
  logic signed [32:0]         apr_r;
  logic signed [DATA_W-1:0]   aval_r;
  logic signed [33:0]         ap;
  logic signed [17:0]         delta;
  logic signed [18:0]         upd_w;
  logic signed [DATA_W-1:0]   upd;
  logic signed [DATA_W-1:0]   wdata;
  logic signed [AccW-1:0]     rnd;
  logic [ACT_W-1:0]           act;
  logic [CNT_W-1:0]           cnt_r;

  logic                       ov_r;
  logic                       ost_r;
  logic [NIDX_W-1:0]          oni_r;
  logic [ACT_W-1:0]           oact_r;
  logic                       oend_r;
  logic                       oload;

  assign addr     = AddrW'(AddrW'(row) * AddrW'(MAX_OUTPUTS)) + AddrW'(col);
  assign bias_val = bv_rd_r ? b_rd_r : '0;
  assign wdata    = cmd.apply_wr ? upd : in_data_value;

  always_ff @(posedge clk) begin
    if (cmd.wr_w) wmem[addr] <= wdata;
    if (cmd.wr_wg) gmem[addr] <= in_data_value;
    if (cmd.wr_b) bmem[col] <= wdata;
    if (cmd.wr_bg) bgmem[col] <= in_data_value;
    if (cmd.push_x && (32'(cnt_r) < MAX_INPUTS)) xmem[RowW'(cnt_r)] <= in_data_value;
    w_rd_r  <= wmem[addr];
    g_rd_r  <= gmem[addr];
    b_rd_r  <= bmem[col];
    bg_rd_r <= bgmem[col];
    x_rd_r  <= xmem[row];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bv_r    <= '0;
      bv_rd_r <= 1'b0;
      v1_r    <= 1'b0;
      v2_r    <= 1'b0;
      cnt_r   <= '0;
      ov_r    <= 1'b0;
    end else begin
      if (cmd.wr_b) bv_r[col] <= 1'b1;
      bv_rd_r <= bv_r[col];
      v1_r    <= cmd.mac_vld;
      v2_r    <= v1_r;
      if (cmd.push_x) begin
        if (cmd.end_vec) cnt_r <= '0;
        else if (32'(cnt_r) != COUNT_MAX) cnt_r <= cnt_r + 1'b1;
      end
      if (oload) ov_r <= 1'b1;
      else if (!out_stall) ov_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    prod_r <= x_rd_r * w_rd_r;
    if (cmd.acc_load) acc_r <= AccW'(bias_val) <<< 8;
    else if (v2_r) acc_r <= acc_r + AccW'(prod_r);
    if (cmd.apply_mul) begin
      apr_r  <= (cmd.sel_bias ? bg_rd_r : g_rd_r) * $signed({1'b0, learn_rate});
      aval_r <= cmd.sel_bias ? bias_val : w_rd_r;
    end
  end

  always_comb begin
    ap    = 34'(apr_r) + 34'sd32768;
    delta = 18'(ap >>> 16);
    upd_w = 19'(aval_r) - 19'(delta);
    if (upd_w > 19'sd32767)       upd = 16'sh7fff;
    else if (upd_w < -19'sd32768) upd = 16'sh8000;
    else                          upd = upd_w[DATA_W-1:0];
  end

  always_comb begin
    rnd = (acc_r + AccW'(128)) >>> 8;
    if (acc_r < 0)                 act = '0;
    else if (rnd > AccW'(ACT_MAX)) act = ACT_W'(ACT_MAX);
    else                           act = rnd[ACT_W-1:0];
  end

  assign oload = cmd.out_load_act || cmd.out_load_err;

  always_ff @(posedge clk) begin
    if (oload) begin
      ost_r  <= cmd.out_load_err ? STATUS_ERR : STATUS_OK;
      oni_r  <= cmd.out_load_err ? '0 : nidx;
      oact_r <= cmd.out_load_err ? '0 : act;
      oend_r <= cmd.out_load_err ? 1'b1 : cmd.out_last;
    end
  end

  assign sts.out_free     = !ov_r || !out_stall;
  assign sts.count        = cnt_r;
  assign out_valid        = ov_r;
  assign out_status       = ost_r;
  assign out_neuron_index = oni_r;
  assign out_activation   = oact_r;
  assign out_run_end      = oend_r;

endmodule

[rtl/dense_layer_relu_sgd.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dense_layer_relu_sgd
// Fully connected Q8.8 layer with ReLU and gradient-descent update.
//
//   port group | direction | flow control   | contents
//   in_*       | sink      | valid / stall  | opcode, indexes, value, end mark
//   out_*      | source    | valid / stall  | status, neuron, activation, end
//   cfg_*      | sink      | valid / ready  | register index, write data
//
// Loads and plain input elements are taken while idle. A matched vector runs
// one product per cycle through a single multiply-accumulate pipe, neuron by
// neuron; a count error sends one error result. Apply steps through read,
// multiply and write for each weight and bias, on one shared update multiplier.
// Reset is synchronous; bias store reads zero until written, no clearing pass.
// A stalled result holds in the output register; the next neuron's result
// waits for it.
// ----------------------------------------------------------------------------
module dense_layer_relu_sgd
  import dlrs_pkg::*;
#(
  parameter int MAX_INPUTS  = 16,
  parameter int MAX_OUTPUTS = 16
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic [2:0]               in_opcode,
  input  logic [3:0]               in_row_index,
  input  logic [3:0]               in_col_index,
  input  logic signed [DATA_W-1:0] in_data_value,
  input  logic                     in_vector_end,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic                     out_status,
  output logic [NIDX_W-1:0]        out_neuron_index,
  output logic [ACT_W-1:0]         out_activation,
  output logic                     out_run_end,
  input  logic                     cfg_valid,
  output logic                     cfg_ready,
  input  logic [CFG_IW-1:0]        cfg_index,
  input  logic [LR_W-1:0]          cfg_data
);

  localparam int RowW = (MAX_INPUTS > 1) ? $clog2(MAX_INPUTS) : 1;
  localparam int ColW = (MAX_OUTPUTS > 1) ? $clog2(MAX_OUTPUTS) : 1;

  cmd_t              cmd;
  sts_t              sts;
  logic [LR_W-1:0]   learn_rate;
  logic [RowW-1:0]   row;
  logic [ColW-1:0]   col;
  logic [NIDX_W-1:0] nidx;

  dlrs_ctrl #(
    .MAX_INPUTS (MAX_INPUTS),
    .MAX_OUTPUTS(MAX_OUTPUTS),
    .RowW       (RowW),
    .ColW       (ColW)
  ) u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_opcode    (in_opcode),
    .in_row_index (in_row_index),
    .in_col_index (in_col_index),
    .in_vector_end(in_vector_end),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .learn_rate   (learn_rate),
    .row          (row),
    .col          (col),
    .nidx         (nidx),
    .cmd          (cmd),
    .sts          (sts)
  );

  dlrs_dp #(
    .MAX_INPUTS (MAX_INPUTS),
    .MAX_OUTPUTS(MAX_OUTPUTS),
    .RowW       (RowW),
    .ColW       (ColW)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_data_value   (in_data_value),
    .learn_rate      (learn_rate),
    .row             (row),
    .col             (col),
    .nidx            (nidx),
    .cmd             (cmd),
    .sts             (sts),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_status      (out_status),
    .out_neuron_index(out_neuron_index),
    .out_activation  (out_activation),
    .out_run_end     (out_run_end)
  );

endmodule

[rtl/dlrs_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dlrs_checker
// Port-level checks of the dense layer, bound to the top level.
// ----------------------------------------------------------------------------
module dlrs_checker
  import dlrs_pkg::*;
(
  input logic              clk,
  input logic              rst_n,
  input logic              in_valid,
  input logic              in_stall,
  input logic [2:0]        in_opcode,
  input logic              in_vector_end,
  input logic              out_valid,
  input logic              out_stall,
  input logic              out_status,
  input logic [NIDX_W-1:0] out_neuron_index,
  input logic [ACT_W-1:0]  out_activation,
  input logic              out_run_end
);

  a_reset_clears_out: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

  a_busy_after_work: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall &&
     ((in_opcode == OP_INPUT && in_vector_end) || in_opcode == OP_APPLY))
    |=> in_stall)
    else $error("input not held off while a vector or update runs");

  a_err_shape: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status == STATUS_ERR)
    |-> (out_run_end && out_activation == '0 && out_neuron_index == '0))
    else $error("malformed error transfer");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> (out_valid && $stable(out_activation) &&
     $stable(out_neuron_index) && $stable(out_status) && $stable(out_run_end)))
    else $error("stalled result changed");

endmodule

bind dense_layer_relu_sgd dlrs_checker u_dlrs_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_valid        (in_valid),
  .in_stall        (in_stall),
  .in_opcode       (in_opcode),
  .in_vector_end   (in_vector_end),
  .out_valid       (out_valid),
  .out_stall       (out_stall),
  .out_status      (out_status),
  .out_neuron_index(out_neuron_index),
  .out_activation  (out_activation),
  .out_run_end     (out_run_end)
);
